>>> rtl/awb_pkg.sv
// ----------------------------------------------------------------------------
// awb_pkg: shared widths, codes and constants for the white-balance gain block
// Ratio and gain widths, register indexes, status codes and the fixed
// numerators used by the two divider chains.
// ----------------------------------------------------------------------------
package awb_pkg;

  // Field widths
  localparam int RATIO_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Ratio 1.0 is 512 (shift of 9), unity gain is 256 (shift of 8)
  localparam int RATIO_ONE_SHIFT = 9;
  localparam int UNITY_SHIFT     = 8;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h0100;

  // Correction ratio divider: 512 * golden / measured
  localparam int CORR_NUM_W = RATIO_W + RATIO_ONE_SHIFT;
  localparam int CORR_DEN_W = RATIO_W;

  // Gain divider: 256 * x / y with y below 512
  localparam int GAIN_NUM_W = RATIO_W + UNITY_SHIFT;
  localparam int GAIN_DEN_W = RATIO_ONE_SHIFT;
  localparam logic [GAIN_NUM_W-1:0] UNITY_X_ONE = 24'd131072;

  // Quotients keep their low bits only
  localparam int QUO_W = GAIN_W;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_GOLDEN_RED  = 2'd0;
  localparam cfg_idx_t REG_GOLDEN_BLUE = 2'd1;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_ZERO_OPERAND = 2'd1;
  localparam status_t ST_ZERO_RATIO   = 2'd2;

endpackage

>>> rtl/awb_div_cell.sv
// ----------------------------------------------------------------------------
// awb_div_cell: one restoring-division step for several lanes
// Takes the next dividend bit into the partial remainder, subtracts the
// divisor when it fits, shifts one quotient bit in and hands everything on.
// ----------------------------------------------------------------------------
module awb_div_cell #(
  parameter int LANES  = 2,
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [SIDE_W-1:0]               in_side,
  input  logic [LANES-1:0][NUM_W-1:0]     in_num,
  input  logic [LANES-1:0][DEN_W-1:0]     in_den,
  input  logic [LANES-1:0][DEN_W-1:0]     in_rem,
  input  logic [LANES-1:0][QUO_W-1:0]     in_quo,
  output logic                            out_valid,
  output logic [SIDE_W-1:0]               out_side,
  output logic [LANES-1:0][NUM_W-1:0]     out_num,
  output logic [LANES-1:0][DEN_W-1:0]     out_den,
  output logic [LANES-1:0][DEN_W-1:0]     out_rem,
  output logic [LANES-1:0][QUO_W-1:0]     out_quo
);

  logic [LANES-1:0][NUM_W-1:0] num_next;
  logic [LANES-1:0][DEN_W-1:0] rem_next;
  logic [LANES-1:0][QUO_W-1:0] quo_next;

  // Trial subtract per lane
  always_comb begin
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;
    trial = '0;
    diff  = '0;
    fits  = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      trial       = {in_rem[l], in_num[l][NUM_W-1]};
      diff        = trial - {1'b0, in_den[l]};
      fits        = (trial >= {1'b0, in_den[l]});
      rem_next[l] = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_next[l] = {in_quo[l][QUO_W-2:0], fits};
      num_next[l] = {in_num[l][NUM_W-2:0], 1'b0};
    end
  end

  // Advance the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    out_side <= in_side;
    out_num  <= num_next;
    out_den  <= in_den;
    out_rem  <= rem_next;
    out_quo  <= quo_next;
  end

endmodule

>>> rtl/awb_div_chain.sv
// ----------------------------------------------------------------------------
// awb_div_chain: row of division cells, one dividend bit per cell
// A word may enter every cycle; its quotients (low bits) leave the last cell
// together with the side data that travels alongside.
// ----------------------------------------------------------------------------
module awb_div_chain #(
  parameter int LANES  = 2,
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [SIDE_W-1:0]           in_side,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [LANES-1:0][DEN_W-1:0] in_den,
  output logic                        out_valid,
  output logic [SIDE_W-1:0]           out_side,
  output logic [LANES-1:0][QUO_W-1:0] out_quo
);

  logic                        valid_w [0:NUM_W];
  logic [SIDE_W-1:0]           side_w  [0:NUM_W];
  logic [LANES-1:0][NUM_W-1:0] num_w   [0:NUM_W];
  logic [LANES-1:0][DEN_W-1:0] den_w   [0:NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem_w   [0:NUM_W];
  logic [LANES-1:0][QUO_W-1:0] quo_w   [0:NUM_W];

  // Feed the head of the row with a clear remainder and quotient
  assign valid_w[0] = in_valid;
  assign side_w[0]  = in_side;
  assign num_w[0]   = in_num;
  assign den_w[0]   = in_den;
  assign rem_w[0]   = '0;
  assign quo_w[0]   = '0;

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    awb_div_cell #(
      .LANES  (LANES),
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_w[k]),
      .in_side   (side_w[k]),
      .in_num    (num_w[k]),
      .in_den    (den_w[k]),
      .in_rem    (rem_w[k]),
      .in_quo    (quo_w[k]),
      .out_valid (valid_w[k+1]),
      .out_side  (side_w[k+1]),
      .out_num   (num_w[k+1]),
      .out_den   (den_w[k+1]),
      .out_rem   (rem_w[k+1]),
      .out_quo   (quo_w[k+1])
    );
  end

  // Tail of the row
  assign out_valid = valid_w[NUM_W];
  assign out_side  = side_w[NUM_W];
  assign out_quo   = quo_w[NUM_W];

endmodule

>>> rtl/awb_gain_from_ratios.sv
// ----------------------------------------------------------------------------
// awb_gain_from_ratios: white-balance channel gains from measured ratios
// Forms correction ratios against the golden ratios, then picks red, green
// and blue gains (256 = unity) so that the smallest gain stays at unity.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Word
//  -------   ------------------   ---------------------------------------------
//  input     start / busy         measured_red_ratio, measured_blue_ratio
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//  result    done (strobe)        red_gain, green_gain, blue_gain, status
//
//  A word is taken every cycle; its result passes through 25 cells of the
//  correction-ratio divider, 24 cells of the gain divider and the output
//  register.
//  Reset clears the pipeline valid flags and both golden ratios to zero;
//  busy is high only while reset is applied.
//  Results are not held: done is high for exactly one cycle per word.
// ----------------------------------------------------------------------------
module awb_gain_from_ratios
  import awb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [RATIO_W-1:0]   measured_red_ratio,
  input  logic [RATIO_W-1:0]   measured_blue_ratio,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATIO_W-1:0]   cfg_data,
  output logic                 done,
  output logic [GAIN_W-1:0]    red_gain,
  output logic [GAIN_W-1:0]    green_gain,
  output logic [GAIN_W-1:0]    blue_gain,
  output logic [STATUS_W-1:0]  status
);

  localparam int SIDE2_W = 1 + 2 * RATIO_W;
  localparam int LATENCY = CORR_NUM_W + GAIN_NUM_W + 1;

  logic [RATIO_W-1:0] golden_red_ratio;
  logic [RATIO_W-1:0] golden_blue_ratio;

  logic                             accept;
  logic                             zero_in;
  logic [1:0][CORR_NUM_W-1:0]       corr_num;
  logic [1:0][CORR_DEN_W-1:0]       corr_den;
  logic                             corr_valid;
  logic                             corr_zero;
  logic [1:0][QUO_W-1:0]            corr_quo;

  logic [RATIO_W-1:0]               r_ratio;
  logic [RATIO_W-1:0]               b_ratio;
  logic [3:0][GAIN_NUM_W-1:0]       gain_num;
  logic [3:0][GAIN_DEN_W-1:0]       gain_den;
  logic [SIDE2_W-1:0]               gain_side_in;
  logic                             gain_valid;
  logic [SIDE2_W-1:0]               gain_side;
  logic [3:0][QUO_W-1:0]            gain_quo;

  logic                             fin_zero;
  logic [RATIO_W-1:0]               fin_r;
  logic [RATIO_W-1:0]               fin_b;
  logic [GAIN_W-1:0]                red_next;
  logic [GAIN_W-1:0]                green_next;
  logic [GAIN_W-1:0]                blue_next;
  status_t                          status_next;

  // Word handshakes
  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Golden ratio registers
  always_ff @(posedge clk) begin
    if (rst) begin
      golden_red_ratio  <= '0;
      golden_blue_ratio <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GOLDEN_RED:  golden_red_ratio  <= cfg_data;
        REG_GOLDEN_BLUE: golden_blue_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

  // Correction ratios: 512 * golden / measured
  assign zero_in = (measured_red_ratio == '0) || (measured_blue_ratio == '0) ||
                   (golden_red_ratio == '0) || (golden_blue_ratio == '0);
  assign corr_num[0] = {golden_red_ratio, {RATIO_ONE_SHIFT{1'b0}}};
  assign corr_num[1] = {golden_blue_ratio, {RATIO_ONE_SHIFT{1'b0}}};
  assign corr_den[0] = measured_red_ratio;
  assign corr_den[1] = measured_blue_ratio;

  awb_div_chain #(
    .LANES  (2),
    .NUM_W  (CORR_NUM_W),
    .DEN_W  (CORR_DEN_W),
    .QUO_W  (QUO_W),
    .SIDE_W (1)
  ) u_corr_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_side   (zero_in),
    .in_num    (corr_num),
    .in_den    (corr_den),
    .out_valid (corr_valid),
    .out_side  (corr_zero),
    .out_quo   (corr_quo)
  );

  // Gain quotients; divisors are only used where the ratio is below 512
  assign r_ratio = corr_quo[0];
  assign b_ratio = corr_quo[1];
  assign gain_num[0] = UNITY_X_ONE;
  assign gain_num[1] = UNITY_X_ONE;
  assign gain_num[2] = {b_ratio, {UNITY_SHIFT{1'b0}}};
  assign gain_num[3] = {r_ratio, {UNITY_SHIFT{1'b0}}};
  assign gain_den[0] = r_ratio[GAIN_DEN_W-1:0];
  assign gain_den[1] = b_ratio[GAIN_DEN_W-1:0];
  assign gain_den[2] = r_ratio[GAIN_DEN_W-1:0];
  assign gain_den[3] = b_ratio[GAIN_DEN_W-1:0];
  assign gain_side_in = {corr_zero, r_ratio, b_ratio};

  awb_div_chain #(
    .LANES  (4),
    .NUM_W  (GAIN_NUM_W),
    .DEN_W  (GAIN_DEN_W),
    .QUO_W  (QUO_W),
    .SIDE_W (SIDE2_W)
  ) u_gain_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corr_valid),
    .in_side   (gain_side_in),
    .in_num    (gain_num),
    .in_den    (gain_den),
    .out_valid (gain_valid),
    .out_side  (gain_side),
    .out_quo   (gain_quo)
  );

  // Pick the gains by branch
  assign fin_zero = gain_side[SIDE2_W-1];
  assign fin_r    = gain_side[2*RATIO_W-1:RATIO_W];
  assign fin_b    = gain_side[RATIO_W-1:0];

  always_comb begin
    logic r_big;
    logic b_big;
    r_big       = |fin_r[RATIO_W-1:RATIO_ONE_SHIFT];
    b_big       = |fin_b[RATIO_W-1:RATIO_ONE_SHIFT];
    red_next    = '0;
    green_next  = '0;
    blue_next   = '0;
    status_next = ST_OK;
    if (fin_zero) begin
      status_next = ST_ZERO_OPERAND;
    end else if (r_big && b_big) begin
      red_next   = {1'b0, fin_r[RATIO_W-1:1]};
      green_next = UNITY_GAIN;
      blue_next  = {1'b0, fin_b[RATIO_W-1:1]};
    end else if (r_big) begin
      if (fin_b == '0) begin
        status_next = ST_ZERO_RATIO;
      end else begin
        red_next   = gain_quo[3];
        green_next = gain_quo[1];
        blue_next  = UNITY_GAIN;
      end
    end else if (b_big) begin
      if (fin_r == '0) begin
        status_next = ST_ZERO_RATIO;
      end else begin
        red_next   = UNITY_GAIN;
        green_next = gain_quo[0];
        blue_next  = gain_quo[2];
      end
    end else if (fin_r == '0 || fin_b == '0) begin
      status_next = ST_ZERO_RATIO;
    end else if (gain_quo[0] >= gain_quo[1]) begin
      red_next   = UNITY_GAIN;
      green_next = gain_quo[0];
      blue_next  = gain_quo[2];
    end else begin
      red_next   = gain_quo[3];
      green_next = gain_quo[1];
      blue_next  = UNITY_GAIN;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= gain_valid;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    red_gain   <= red_next;
    green_gain <= green_next;
    blue_gain  <= blue_next;
    status     <= status_next;
  end

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result strobe missing after fixed latency");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_ZERO_OPERAND || status == ST_ZERO_RATIO))
    else $error("undefined status code");

  a_error_gains : assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |->
      (red_gain == '0 && green_gain == '0 && blue_gain == '0))
    else $error("gains not cleared on error");

  a_unity_kept : assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |->
      (red_gain == UNITY_GAIN || green_gain == UNITY_GAIN || blue_gain == UNITY_GAIN))
    else $error("no channel left at unity gain");
`endif

endmodule
